### hdl/interval_overlap_measure_unit_defines.svh
// ----------------------------------------------------------------------------
// Interval overlap measure assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_OVERLAP_MEASURE_UNIT_DEFINES_SVH
`define INTERVAL_OVERLAP_MEASURE_UNIT_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define IOM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: expr");

// Antecedent implies consequent sequence.
`define IOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed: ante implies cons");

`endif

### hdl/iom_pkg.sv
// ----------------------------------------------------------------------------
// Interval overlap measure package
// Widths, the overlap class codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package iom_pkg;

	localparam int CoordW     = 16;
	localparam int LenW       = 16;
	localparam int RatioW     = 16;
	localparam int ScaleShift = 4;                 // ratio scale of 16
	localparam int DvdW       = LenW + ScaleShift;
	localparam int DivBits    = 4;                 // quotient bits per divider stage
	localparam int DivStages  = DvdW / DivBits;
	localparam int Latency    = DivStages + 3;

	localparam logic [RatioW-1:0] RatioMax = '1;

	typedef enum logic [1:0] {
		CLS_MAJOR    = 2'd0,
		CLS_MINOR    = 2'd1,
		CLS_SMALL    = 2'd2,
		CLS_DISJOINT = 2'd3
	} ovl_class_t;

	typedef struct packed {
		logic            disjoint;
		logic [LenW-1:0] overlap;
		logic [LenW-1:0] len1;
		logic [LenW-1:0] len2;
		logic [LenW-1:0] gap;
	} prep_t;

	typedef struct packed {
		logic              disjoint;
		ovl_class_t        cls;
		logic [RatioW-1:0] gap;
	} side_t;

endpackage

### hdl/iom_front.sv
// ----------------------------------------------------------------------------
// Interval overlap front end
// Two stages: bounds and lengths, then overlap, gap and disjoint flag.
// ----------------------------------------------------------------------------
module iom_front import iom_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	input  logic signed [CoordW-1:0] first_begin,
	input  logic signed [CoordW-1:0] first_end,
	input  logic signed [CoordW-1:0] second_begin,
	input  logic signed [CoordW-1:0] second_end,
	output logic                     valid_s2,
	output prep_t                    prep_s2
);

	logic                     valid_s1;
	logic signed [CoordW-1:0] lo_s1;
	logic signed [CoordW-1:0] hi_s1;
	logic [LenW-1:0]          len1_s1;
	logic [LenW-1:0]          len2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// Overlap runs from the larger begin to the smaller end.
	always_ff @(posedge clk) begin
		lo_s1   <= (first_begin > second_begin) ? first_begin : second_begin;
		hi_s1   <= (first_end < second_end) ? first_end : second_end;
		len1_s1 <= LenW'(first_end - first_begin + CoordW'(1));
		len2_s1 <= LenW'(second_end - second_begin + CoordW'(1));
	end

	always_ff @(posedge clk) begin
		prep_s2.disjoint <= lo_s1 > hi_s1;
		prep_s2.overlap  <= LenW'(hi_s1 - lo_s1 + CoordW'(1));
		prep_s2.gap      <= LenW'(lo_s1 - hi_s1);
		prep_s2.len1     <= len1_s1;
		prep_s2.len2     <= len2_s1;
	end

endmodule

### hdl/iom_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Resolves a fixed number of quotient bits per stage and saturates the result.
// ----------------------------------------------------------------------------
module iom_div import iom_pkg::*; (
	input  logic              clk,
	input  logic [DvdW-1:0]   dividend,
	input  logic [LenW-1:0]   divisor,
	output logic [RatioW-1:0] quotient
);

	logic [LenW-1:0] rem_s [DivStages-1];
	logic [DvdW-1:0] dvd_s [DivStages-1];
	logic [LenW-1:0] dsr_s [DivStages-1];
	logic [DvdW-1:0] quo_s [DivStages];

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [LenW-1:0] rem_in;
		logic [DvdW-1:0] dvd_in;
		logic [DvdW-1:0] quo_in;
		logic [LenW-1:0] dsr_in;
		logic [LenW-1:0] rem_nx;
		logic [DvdW-1:0] dvd_nx;
		logic [DvdW-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = dividend;
			assign quo_in = '0;
			assign dsr_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign quo_in = quo_s[k-1];
			assign dsr_in = dsr_s[k-1];
		end

		// A zero divisor makes every trial succeed, so the quotient comes out
		// all ones and saturates.
		always_comb begin
			logic [LenW:0] trial;
			rem_nx = rem_in;
			dvd_nx = dvd_in;
			quo_nx = quo_in;
			for (int i = 0; i < DivBits; i++) begin
				trial  = {rem_nx, dvd_nx[DvdW-1]};
				dvd_nx = {dvd_nx[DvdW-2:0], 1'b0};
				if (trial >= {1'b0, dsr_in}) begin
					trial  = trial - {1'b0, dsr_in};
					quo_nx = {quo_nx[DvdW-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[DvdW-2:0], 1'b0};
				end
				rem_nx = trial[LenW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k] <= quo_nx;
		end

		if (k < DivStages - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= rem_nx;
				dvd_s[k] <= dvd_nx;
				dsr_s[k] <= dsr_in;
			end
		end
	end

	assign quotient = (|quo_s[DivStages-1][DvdW-1:RatioW]) ? RatioMax
		: quo_s[DivStages-1][RatioW-1:0];

endmodule

### hdl/interval_overlap_measure_unit.sv
// ----------------------------------------------------------------------------
// Interval overlap measure unit
// Overlap class and scaled overlap ratios of two closed integer intervals.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the four signed 16-bit interval bounds and raise start for one
//   cycle per word. A word is taken at every rising edge where start is high
//   and busy is low; busy is never raised, so a new word may enter on every
//   clock cycle.
//   Each word produces exactly one result word: overlap_class, ratio_first
//   and ratio_second are shown for a single cycle with done high. Results
//   leave in the order words came. Throughput is one word per cycle. A word
//   passes two front-end stages, then the two pipelined ratio dividers,
//   which resolve four quotient bits per stage over five stages, and then
//   one output register.
//   The receiver has no way to hold results off; it must take each word in
//   the cycle done is high.
//   Reset (arst_n low) clears every valid bit at once, so no result word
//   comes out of a word that was in flight when reset arrived.
// ----------------------------------------------------------------------------
module interval_overlap_measure_unit import iom_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] first_begin,
	input  logic signed [CoordW-1:0] first_end,
	input  logic signed [CoordW-1:0] second_begin,
	input  logic signed [CoordW-1:0] second_end,
	output logic                     done,
	output logic [1:0]               overlap_class,
	output logic [RatioW-1:0]        ratio_first,
	output logic [RatioW-1:0]        ratio_second
);

	logic              valid_s2;
	prep_t             prep_s2;
	ovl_class_t        cls_nx;
	logic [LenW-1:0]   lmin;
	logic [LenW-1:0]   lmax;
	logic [LenW:0]     twice;
	logic [DvdW-1:0]   dvd1;
	logic [DvdW-1:0]   dvd2;
	logic [RatioW-1:0] quo1;
	logic [RatioW-1:0] quo2;
	logic              vld_s [DivStages];
	side_t             side_s [DivStages];

	// The pipeline never stalls, so the block is always ready for a word.
	assign busy = 1'b0;

	iom_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (start),
		.first_begin  (first_begin),
		.first_end    (first_end),
		.second_begin (second_begin),
		.second_end   (second_end),
		.valid_s2     (valid_s2),
		.prep_s2      (prep_s2)
	);

	// Both ratios are sixteen times the overlap over the interval length.
	assign dvd1 = {prep_s2.overlap, {ScaleShift{1'b0}}};
	assign dvd2 = {prep_s2.overlap, {ScaleShift{1'b0}}};

	iom_div u_div_first (
		.clk      (clk),
		.dividend (dvd1),
		.divisor  (prep_s2.len1),
		.quotient (quo1)
	);

	iom_div u_div_second (
		.clk      (clk),
		.dividend (dvd2),
		.divisor  (prep_s2.len2),
		.quotient (quo2)
	);

	// Class compares twice the overlap with the wrapped lengths at full width.
	always_comb begin
		lmin  = (prep_s2.len1 < prep_s2.len2) ? prep_s2.len1 : prep_s2.len2;
		lmax  = (prep_s2.len1 < prep_s2.len2) ? prep_s2.len2 : prep_s2.len1;
		twice = {prep_s2.overlap, 1'b0};
		if (twice > {1'b0, lmax}) begin
			cls_nx = CLS_MAJOR;
		end else if (twice > {1'b0, lmin}) begin
			cls_nx = CLS_MINOR;
		end else begin
			cls_nx = CLS_SMALL;
		end
	end

	// Side information travels alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DivStages; i++) begin
				vld_s[i] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			vld_s[0] <= valid_s2;
			for (int i = 1; i < DivStages; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			done <= vld_s[DivStages-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].disjoint <= prep_s2.disjoint;
		side_s[0].cls      <= cls_nx;
		side_s[0].gap      <= prep_s2.gap;
		for (int i = 1; i < DivStages; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	// Disjoint intervals report the gap in the first ratio and zero in the second.
	always_ff @(posedge clk) begin
		if (side_s[DivStages-1].disjoint) begin
			overlap_class <= CLS_DISJOINT;
			ratio_first   <= side_s[DivStages-1].gap;
			ratio_second  <= '0;
		end else begin
			overlap_class <= side_s[DivStages-1].cls;
			ratio_first   <= quo1;
			ratio_second  <= quo2;
		end
	end

endmodule

### hdl/iom_checker.sv
// ----------------------------------------------------------------------------
// Interval overlap measure checker
// Port-level checks on word timing and disjoint results, bound to the top.
// ----------------------------------------------------------------------------
`include "interval_overlap_measure_unit_defines.svh"

module iom_checker import iom_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic signed [CoordW-1:0] first_begin,
	input logic signed [CoordW-1:0] first_end,
	input logic signed [CoordW-1:0] second_begin,
	input logic signed [CoordW-1:0] second_end,
	input logic                     done,
	input logic [1:0]               overlap_class,
	input logic [RatioW-1:0]        ratio_first,
	input logic [RatioW-1:0]        ratio_second
);

	// A taken word must produce a result when it leaves the pipeline.
	`IOM_ASSERT_IMPL(a_word_yields_result, clk, arst_n, start && !busy, ##Latency done)

	// A result word must come from a word taken earlier at the input.
	`IOM_ASSERT_IMPL(a_result_has_word, clk, arst_n, done, $past(start && !busy, Latency))

	// Disjoint intervals carry a zero second ratio.
	`IOM_ASSERT_IMPL(a_disjoint_zero, clk, arst_n, done && overlap_class == CLS_DISJOINT, ratio_second == '0)

	// The unit never holds the sender off.
	`IOM_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)

endmodule

bind interval_overlap_measure_unit iom_checker u_iom_checker (.*);
